// ----- rtl/lj_pair_force_accumulator_assert.svh -----
// ----------------------------------------------------------------------------
// LJ pair force accumulator assertion macros
// Clocked property checks on clk with synchronous reset rst as disable.
// ----------------------------------------------------------------------------
`ifndef LJ_PAIR_FORCE_ACCUMULATOR_ASSERT_SVH
`define LJ_PAIR_FORCE_ACCUMULATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define LJPF_ASSERT_IMPLY(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define LJPF_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`else

`define LJPF_ASSERT_IMPLY(lbl, a, b, msg)
`define LJPF_ASSERT_NEXT(lbl, a, b, msg)

`endif

`endif

// ----- rtl/ljpf_pkg.sv -----
// ----------------------------------------------------------------------------
// ljpf_pkg
// Types, constants and saturation helpers for the LJ pair force accumulator.
// ----------------------------------------------------------------------------
package ljpf_pkg;

  localparam int ACC_W   = 48;   // accumulator width, 32..64
  localparam int OUT_W   = 48;   // result field width
  localparam int Q_DEPTH = 4;    // pair queue depth
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [7:0] REG_CUTOFF_SQ    = 8'd0;
  localparam logic [7:0] REG_SIGMA6       = 8'd1;
  localparam logic [7:0] REG_ENERGY_SHIFT = 8'd2;
  localparam logic [7:0] REG_FOUR_EPSILON = 8'd3;

  localparam logic [31:0] RST_CUTOFF_SQ    = 32'd2191011;
  localparam logic [31:0] RST_SIGMA6       = 32'd10114888;
  localparam logic [31:0] RST_ENERGY_SHIFT = 32'hFFFF_FEF4;
  localparam logic [31:0] RST_FOUR_EPSILON = 32'd43778;

  localparam logic signed [66:0] SAT_HI = (67'sd1 <<< (ACC_W - 1)) - 67'sd1;
  localparam logic signed [66:0] SAT_LO = -SAT_HI - 67'sd1;

  typedef struct packed {
    logic signed [31:0] home_x;
    logic signed [31:0] home_y;
    logic signed [31:0] home_z;
    logic signed [31:0] neighbor_x;
    logic signed [31:0] neighbor_y;
    logic signed [31:0] neighbor_z;
    logic               last_pair;
    logic               end_of_pass;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] atom_energy;
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic signed [OUT_W-1:0] force_z;
    logic signed [OUT_W-1:0] total_energy;
    logic                    total_valid;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        cutoff_sq;
    logic [31:0]        sigma6;
    logic signed [31:0] energy_shift;
    logic [31:0]        four_epsilon;
  } cfg_t;

  // classified pair: per-axis |dr| and sign of dr, plus run flags
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             last_pair;
    logic             end_of_pass;
  } pair_t;

  // add a wide signed term to an accumulator, clamp to the accumulator range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [65:0] b);
    logic signed [66:0] s;
    s = 67'(a) + 67'(b);
    if (s > SAT_HI) return ACC_W'(SAT_HI);
    if (s < SAT_LO) return ACC_W'(SAT_LO);
    return ACC_W'(s);
  endfunction

  // cap magnitude at 2^63-1 and apply sign
  function automatic logic signed [65:0] sign_cap(input logic [63:0] mag, input logic neg);
    logic [63:0] m;
    m = mag[63] ? {1'b0, {63{1'b1}}} : mag;
    return neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
  endfunction

endpackage

// ----- rtl/ljpf_front.sv -----
// ----------------------------------------------------------------------------
// ljpf_front
// Forms per-axis distance magnitude and sign for an incoming pair.
// ----------------------------------------------------------------------------
module ljpf_front (
  input  ljpf_pkg::in_item_t in_item,
  output ljpf_pkg::pair_t    pair
);

  function automatic logic [32:0] axis(input logic signed [31:0] h,
                                       input logic signed [31:0] n);
    logic signed [32:0] d;
    logic signed [32:0] nd;
    d  = 33'(h) - 33'(n);
    nd = -d;
    return d[32] ? {1'b1, nd[31:0]} : {1'b0, d[31:0]};
  endfunction

  logic [32:0] ax, ay, az;

  assign ax = axis(in_item.home_x, in_item.neighbor_x);
  assign ay = axis(in_item.home_y, in_item.neighbor_y);
  assign az = axis(in_item.home_z, in_item.neighbor_z);

  always_comb begin
    pair.mag[0]      = ax[31:0];
    pair.mag[1]      = ay[31:0];
    pair.mag[2]      = az[31:0];
    pair.neg         = {az[32], ay[32], ax[32]};
    pair.last_pair   = in_item.last_pair;
    pair.end_of_pass = in_item.end_of_pass;
  end

endmodule

// ----- rtl/ljpf_queue.sv -----
// ----------------------------------------------------------------------------
// ljpf_queue
// Short FIFO of classified pairs between front and back.
// ----------------------------------------------------------------------------
module ljpf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  ljpf_pkg::pair_t wr_data,
  output logic            full,
  input  logic            rd,
  output logic            valid,
  output ljpf_pkg::pair_t rd_data
);

  ljpf_pkg::pair_t             slots [ljpf_pkg::Q_DEPTH];
  logic [ljpf_pkg::Q_AW-1:0]   wr_ptr, rd_ptr;
  logic [ljpf_pkg::Q_AW:0]     count;
  logic                        wr_ok, rd_ok;

  assign full    = (count == (ljpf_pkg::Q_AW + 1)'(ljpf_pkg::Q_DEPTH));
  assign valid   = (count != '0);
  assign rd_data = slots[rd_ptr];
  assign wr_ok   = wr && !full;
  assign rd_ok   = rd && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_ok) begin
        slots[wr_ptr] <= wr_data;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (rd_ok) rd_ptr <= rd_ptr + 1'b1;
      case ({wr_ok, rd_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/ljpf_div.sv -----
// ----------------------------------------------------------------------------
// ljpf_div
// Radix-2 restoring divider: (2^64-1) / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ljpf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] rem;
  logic [63:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [64:0] rs;
  logic        ge;

  assign rs = {rem, 1'b1};   // dividend is all ones
  assign ge = (rs >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        dsr  <= den;
        cnt  <= '0;
      end else if (busy) begin
        rem <= ge ? 64'(rs - {1'b0, dsr}) : rs[63:0];
        quo <= {quo[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/ljpf_back.sv -----
// ----------------------------------------------------------------------------
// ljpf_back
// Pair sequencer: distance, cutoff, reciprocal, LJ terms and run sums.
// ----------------------------------------------------------------------------
module ljpf_back (
  input  logic                clk,
  input  logic                rst,
  input  ljpf_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  ljpf_pkg::pair_t     q_data,
  output logic                q_pop,
  output logic                div_start,
  output logic [63:0]         div_den,
  input  logic                div_done,
  input  logic [63:0]         div_quo,
  input  logic                pop,
  output logic                out_valid,
  output ljpf_pkg::out_item_t out_item
);

  localparam int AW = ljpf_pkg::ACC_W;
  localparam logic [63:0] R12_LIM = 64'hFFFF_FFFF_FFFF_FFFF / 64'd12;
  localparam logic [63:0] SIX     = 64'd6 << 32;
  localparam logic [63:0] E_CAP   = 64'd1 << 62;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_CHK, S_DIV, S_MUL, S_FIN, S_CALC, S_END, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    M_II, M_I3, M_R6, M_T, M_G1, M_G2, M_G, M_FX, M_FY, M_FZ, M_TOT
  } mop_t;

  state_t          state;
  mop_t            op;
  ljpf_pkg::pair_t cur;
  logic [1:0]      sq_i;
  logic [1:0]      pc;
  logic [63:0]     r2, inv, r6, t, k, g, mul_a, mul_b;
  logic            kneg;
  logic [127:0]    prod;
  logic signed [AW-1:0] run_e, run_fx, run_fy, run_fz, pass_e, tot;

  logic [31:0]  mx, my;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [64:0]  r2_sum;
  logic [63:0]  r2_next;
  logic         in_range;
  logic [63:0]  mres;
  logic [63:0]  d_pos, d_cap;
  logic signed [65:0] e_raw, e_adj, h;
  logic [63:0]  r12, k_next;
  logic         kneg_next;
  logic signed [63:0] pe_ext;
  logic [63:0]  pm;

  // one shared 32x32 multiplier
  always_comb begin
    if (state == S_SQ) begin
      case (sq_i)
        2'd0:    mx = cur.mag[0];
        2'd1:    mx = cur.mag[1];
        default: mx = cur.mag[2];
      endcase
      my = mx;
    end else begin
      mx = pc[1] ? mul_a[63:32] : mul_a[31:0];
      my = pc[0] ? mul_b[63:32] : mul_b[31:0];
    end
  end

  assign pp = 64'(mx) * 64'(my);

  always_comb begin
    case (pc)
      2'd0:    pp_sh = {64'b0, pp};
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
  end

  assign r2_sum   = {1'b0, r2} + {1'b0, pp};
  assign r2_next  = r2_sum[64] ? '1 : r2_sum[63:0];
  assign in_range = (r2 != '0) && (r2 <= 64'({cfg.cutoff_sq, 16'h0000}));

  // product scaling and saturation per op
  always_comb begin
    case (op)
      M_FX, M_FY, M_FZ: mres = (|prod[127:88]) ? '1 : prod[87:24];
      M_TOT:            mres = (|prod[127:80]) ? '1 : prod[79:16];
      default:          mres = (|prod[127:96]) ? '1 : prod[95:32];
    endcase
  end

  // energy and force factor prep
  always_comb begin
    d_pos = t - r6;
    d_cap = (d_pos > E_CAP) ? E_CAP : d_pos;
    if (t >= r6) e_raw = $signed({2'b00, d_cap});
    else         e_raw = -$signed({2'b00, 64'(r6 - t)});
    e_adj     = e_raw - (66'(cfg.energy_shift) <<< 16);
    h         = e_adj >>> 9;
    r12       = (r6 > R12_LIM) ? '1 : 64'((r6 << 3) + (r6 << 2));
    kneg_next = (r12 < SIX);
    k_next    = kneg_next ? 64'(SIX - r12) : 64'(r12 - SIX);
  end

  assign pe_ext = 64'(pass_e);
  assign pm     = pe_ext[63] ? 64'(-pe_ext) : 64'(pe_ext);

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign div_start = (state == S_CHK) && in_range;
  assign div_den   = r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      run_e     <= '0;
      run_fx    <= '0;
      run_fy    <= '0;
      run_fz    <= '0;
      pass_e    <= '0;
    end else begin
      if (pop && out_valid && (state != S_EMIT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_data;
            r2    <= '0;
            sq_i  <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          r2 <= r2_next;
          if (sq_i == 2'd2) state <= S_CHK;
          else sq_i <= sq_i + 2'd1;
        end
        S_CHK: state <= in_range ? S_DIV : S_END;
        S_DIV: begin
          if (div_done) begin
            inv   <= div_quo;
            mul_a <= div_quo;
            mul_b <= div_quo;
            op    <= M_II;
            pc    <= '0;
            prod  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= prod + pp_sh;
          pc   <= pc + 2'd1;
          if (pc == 2'd3) state <= S_FIN;
        end
        S_FIN: begin
          pc    <= '0;
          prod  <= '0;
          state <= S_MUL;
          case (op)
            M_II: begin
              mul_a <= mres;
              mul_b <= inv;
              op    <= M_I3;
            end
            M_I3: begin
              mul_a <= 64'({cfg.sigma6, 16'h0000});
              mul_b <= mres;
              op    <= M_R6;
            end
            M_R6: begin
              r6    <= mres;
              mul_a <= mres;
              mul_b <= mres;
              op    <= M_T;
            end
            M_T: begin
              t     <= mres;
              state <= S_CALC;
            end
            M_G1: begin
              mul_a <= mres;
              mul_b <= inv;
              op    <= M_G2;
            end
            M_G2: begin
              mul_a <= mres;
              mul_b <= k;
              op    <= M_G;
            end
            M_G: begin
              g     <= mres;
              mul_a <= 64'(cur.mag[0]);
              mul_b <= mres;
              op    <= M_FX;
            end
            M_FX: begin
              run_fx <= ljpf_pkg::sat_acc(run_fx, ljpf_pkg::sign_cap(mres, cur.neg[0] ^ kneg));
              mul_a  <= 64'(cur.mag[1]);
              mul_b  <= g;
              op     <= M_FY;
            end
            M_FY: begin
              run_fy <= ljpf_pkg::sat_acc(run_fy, ljpf_pkg::sign_cap(mres, cur.neg[1] ^ kneg));
              mul_a  <= 64'(cur.mag[2]);
              mul_b  <= g;
              op     <= M_FZ;
            end
            M_FZ: begin
              run_fz <= ljpf_pkg::sat_acc(run_fz, ljpf_pkg::sign_cap(mres, cur.neg[2] ^ kneg));
              state  <= S_END;
            end
            M_TOT: begin
              tot   <= ljpf_pkg::sat_acc('0, ljpf_pkg::sign_cap(mres, pass_e[AW-1]));
              state <= S_EMIT;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_CALC: begin
          run_e  <= ljpf_pkg::sat_acc(run_e, h);
          pass_e <= ljpf_pkg::sat_acc(pass_e, h);
          k      <= k_next;
          kneg   <= kneg_next;
          mul_a  <= 64'({cfg.four_epsilon, 16'h0000});
          mul_b  <= r6;
          op     <= M_G1;
          pc     <= '0;
          prod   <= '0;
          state  <= S_MUL;
        end
        S_END: begin
          if (!(cur.last_pair || cur.end_of_pass)) begin
            state <= S_IDLE;
          end else if (cur.end_of_pass) begin
            mul_a <= pm;
            mul_b <= 64'(cfg.four_epsilon);
            op    <= M_TOT;
            pc    <= '0;
            prod  <= '0;
            state <= S_MUL;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || pop) begin
            out_valid             <= 1'b1;
            out_item.atom_energy  <= ljpf_pkg::OUT_W'(run_e);
            out_item.force_x      <= ljpf_pkg::OUT_W'(run_fx);
            out_item.force_y      <= ljpf_pkg::OUT_W'(run_fy);
            out_item.force_z      <= ljpf_pkg::OUT_W'(run_fz);
            out_item.total_energy <= cur.end_of_pass ? ljpf_pkg::OUT_W'(tot) : '0;
            out_item.total_valid  <= cur.end_of_pass;
            run_e  <= '0;
            run_fx <= '0;
            run_fy <= '0;
            run_fz <= '0;
            if (cur.end_of_pass) pass_e <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/lj_pair_force_accumulator.sv -----
// ----------------------------------------------------------------------------
// lj_pair_force_accumulator
// Shifted Lennard-Jones 12-6 pair energy and force, accumulated per home atom.
// ----------------------------------------------------------------------------
// Each item is one atom pair (home and neighbor position, signed Q16.16).
// Pairs with a nonzero squared distance inside cutoff_sq add half their
// shifted 12-6 energy and their force to the run sums (signed Q24.24,
// saturating). last_pair or end_of_pass closes a run: one result item carries
// the run sums and they clear; end_of_pass also carries the pass energy times
// four_epsilon with total_valid set. Other pairs give no result item.
// Flow: the front classifies a pair in the accept cycle and parks it in a
// four-entry queue, so up to four pairs are taken at full speed. The back
// handles one pair at a time; a pair inside the cutoff runs the 64-step
// radix-2 reciprocal divider and then ten 64x64 products, each of four
// passes over one shared 32x32 multiplier and a finish step. A closing pair
// also passes through the emit state, and the end of a pass adds one more
// product. Finished results sit in an output register; the back waits only
// if that register is still held.
// Config writes are taken every cycle (cfg_ready is tied high); indexes past
// the last register are dropped. Write config only while the block is idle.
// ----------------------------------------------------------------------------
`include "lj_pair_force_accumulator_assert.svh"

module lj_pair_force_accumulator (
  input  logic                clk,
  input  logic                rst,
  // pair input
  input  logic                push,
  output logic                full,
  input  ljpf_pkg::in_item_t  in_item,
  // results
  output logic                empty,
  input  logic                pop,
  output ljpf_pkg::out_item_t out_item,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  ljpf_pkg::cfg_t  cfg;
  ljpf_pkg::pair_t f_pair;
  ljpf_pkg::pair_t q_data;
  logic            q_valid, q_pop;
  logic            div_start, div_done;
  logic [63:0]     div_den, div_quo;
  logic            out_valid;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cutoff_sq    <= ljpf_pkg::RST_CUTOFF_SQ;
      cfg.sigma6       <= ljpf_pkg::RST_SIGMA6;
      cfg.energy_shift <= ljpf_pkg::RST_ENERGY_SHIFT;
      cfg.four_epsilon <= ljpf_pkg::RST_FOUR_EPSILON;
    end else if (cfg_valid) begin
      case (cfg_index)
        ljpf_pkg::REG_CUTOFF_SQ:    cfg.cutoff_sq    <= cfg_data;
        ljpf_pkg::REG_SIGMA6:       cfg.sigma6       <= cfg_data;
        ljpf_pkg::REG_ENERGY_SHIFT: cfg.energy_shift <= cfg_data;
        ljpf_pkg::REG_FOUR_EPSILON: cfg.four_epsilon <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: per-axis |dr| and sign
  ljpf_front u_front (
    .in_item (in_item),
    .pair    (f_pair)
  );

  // decoupling queue
  ljpf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (f_pair),
    .full    (full),
    .rd      (q_pop),
    .valid   (q_valid),
    .rd_data (q_data)
  );

  // reciprocal of r2
  ljpf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // back: sequencer, accumulators and output register
  ljpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .div_start (div_start),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quo   (div_quo),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign empty = !out_valid;

  // a full queue always offers a head entry
  `LJPF_ASSERT_IMPLY(a_full_has_head, full, q_valid, "queue full without head entry")
  // an accepted pair is visible to the back next cycle
  `LJPF_ASSERT_NEXT(a_push_lands, push && !full, q_valid, "accepted pair lost in queue")
  // total energy is zero unless flagged
  `LJPF_ASSERT_IMPLY(a_total_zero, !empty && !out_item.total_valid,
                     out_item.total_energy == '0, "total energy set without total_valid")

endmodule

// ----- sim/lj_pair_force_checker.sv -----
// ----------------------------------------------------------------------------
// LJ pair force checker
// Watches the pair, result and register channels of the accumulator, predicts
// every result item from its own copy of the registers and run sums, and
// compares each popped item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lj_pair_force_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  ljpf_pkg::in_item_t  in_item,
  input  logic                empty,
  input  logic                pop,
  input  ljpf_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  errors,
  output int                  pending
);

  logic [31:0]         cut_sq, sig6, fe;
  logic signed [31:0]  e_shift;
  longint              acc_e, acc_fx, acc_fy, acc_fz, acc_pass;
  ljpf_pkg::out_item_t sums_q[$];

  assign pending = sums_q.size();

  // (a*b) >> n, clamped to 64 bits
  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int n);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> n;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic longint clamp_add(longint a, longint b);
    logic signed [66:0] s;
    s = 67'(a) + 67'(b);
    if (s > ljpf_pkg::SAT_HI) return longint'(ljpf_pkg::SAT_HI);
    if (s < ljpf_pkg::SAT_LO) return longint'(ljpf_pkg::SAT_LO);
    return longint'(s);
  endfunction

  function automatic longint signed_cap(logic [63:0] mag, bit neg);
    if (mag[63]) mag = 64'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // one pair through the force model; has_sum set when a run closes
  task automatic accumulate_pair(input ljpf_pkg::in_item_t it, output bit has_sum,
                                 output ljpf_pkg::out_item_t sum);
    longint       dr[3];
    logic [63:0]  ad[3];
    logic [65:0]  r2w;
    logic [63:0]  r2, inv, r6, t, r12, k, g, d, pm;
    longint       e, h, tot;
    bit           kneg;
    dr[0] = longint'(it.home_x) - longint'(it.neighbor_x);
    dr[1] = longint'(it.home_y) - longint'(it.neighbor_y);
    dr[2] = longint'(it.home_z) - longint'(it.neighbor_z);
    r2w = '0;
    for (int i = 0; i < 3; i++) begin
      ad[i] = (dr[i] < 0) ? 64'(-dr[i]) : 64'(dr[i]);
      r2w = r2w + 66'(ad[i] * ad[i]);
    end
    r2 = (r2w[65:64] != 0) ? '1 : r2w[63:0];

    if (r2 != 0 && r2 <= {16'd0, cut_sq, 16'd0}) begin
      inv = 64'hFFFF_FFFF_FFFF_FFFF / r2;
      r6 = mul_shr({16'd0, sig6, 16'd0}, mul_shr(mul_shr(inv, inv, 32), inv, 32), 32);
      t = mul_shr(r6, r6, 32);
      if (t >= r6) begin
        d = t - r6;
        if (d > (64'd1 << 62)) d = 64'd1 << 62;
        e = longint'(d);
      end else begin
        e = -longint'(r6 - t);
      end
      e = e - longint'(e_shift) * 65536;
      // half energy, rounded toward minus infinity
      h = (e >= 0) ? (e >>> 9) : -longint'((64'(-e) + 64'd511) >> 9);
      acc_e = clamp_add(acc_e, h);
      acc_pass = clamp_add(acc_pass, h);

      r12 = (r6 > 64'hFFFF_FFFF_FFFF_FFFF / 12) ? '1 : r6 * 12;
      kneg = r12 < (64'd6 << 32);
      k = kneg ? (64'd6 << 32) - r12 : r12 - (64'd6 << 32);
      g = mul_shr(mul_shr(mul_shr({16'd0, fe, 16'd0}, r6, 32), inv, 32), k, 32);
      acc_fx = clamp_add(acc_fx, signed_cap(mul_shr(ad[0], g, 24), (dr[0] < 0) != kneg));
      acc_fy = clamp_add(acc_fy, signed_cap(mul_shr(ad[1], g, 24), (dr[1] < 0) != kneg));
      acc_fz = clamp_add(acc_fz, signed_cap(mul_shr(ad[2], g, 24), (dr[2] < 0) != kneg));
    end

    has_sum = it.last_pair || it.end_of_pass;
    sum = '0;
    if (has_sum) begin
      sum.atom_energy = acc_e[ljpf_pkg::OUT_W-1:0];
      sum.force_x = acc_fx[ljpf_pkg::OUT_W-1:0];
      sum.force_y = acc_fy[ljpf_pkg::OUT_W-1:0];
      sum.force_z = acc_fz[ljpf_pkg::OUT_W-1:0];
      acc_e = 0; acc_fx = 0; acc_fy = 0; acc_fz = 0;
      if (it.end_of_pass) begin
        pm = (acc_pass < 0) ? 64'(-acc_pass) : 64'(acc_pass);
        tot = clamp_add(signed_cap(mul_shr(pm, {32'd0, fe}, 16), acc_pass < 0), 0);
        sum.total_energy = tot[ljpf_pkg::OUT_W-1:0];
        sum.total_valid = 1'b1;
        acc_pass = 0;
      end
    end
  endtask

  task automatic mismatch(string field, logic [63:0] exp_v, logic [63:0] act_v);
    errors++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    bit                  has_sum;
    ljpf_pkg::out_item_t sum, want;
    if (rst) begin
      cut_sq <= ljpf_pkg::RST_CUTOFF_SQ;
      sig6 <= ljpf_pkg::RST_SIGMA6;
      e_shift <= ljpf_pkg::RST_ENERGY_SHIFT;
      fe <= ljpf_pkg::RST_FOUR_EPSILON;
      acc_e = 0; acc_fx = 0; acc_fy = 0; acc_fz = 0; acc_pass = 0;
      sums_q.delete();
    end else begin
      if (pop && !empty) begin
        if (sums_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item, got %h", $time, out_item);
        end else begin
          want = sums_q.pop_front();
          if (out_item.atom_energy !== want.atom_energy)
            mismatch("atom_energy", 64'(want.atom_energy), 64'(out_item.atom_energy));
          if (out_item.force_x !== want.force_x)
            mismatch("force_x", 64'(want.force_x), 64'(out_item.force_x));
          if (out_item.force_y !== want.force_y)
            mismatch("force_y", 64'(want.force_y), 64'(out_item.force_y));
          if (out_item.force_z !== want.force_z)
            mismatch("force_z", 64'(want.force_z), 64'(out_item.force_z));
          if (out_item.total_energy !== want.total_energy)
            mismatch("total_energy", 64'(want.total_energy), 64'(out_item.total_energy));
          if (out_item.total_valid !== want.total_valid)
            mismatch("total_valid", 64'(want.total_valid), 64'(out_item.total_valid));
        end
      end
      if (push && !full) begin
        accumulate_pair(in_item, has_sum, sum);
        if (has_sum) sums_q.push_back(sum);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ljpf_pkg::REG_CUTOFF_SQ:    cut_sq <= cfg_data;
          ljpf_pkg::REG_SIGMA6:       sig6 <= cfg_data;
          ljpf_pkg::REG_ENERGY_SHIFT: e_shift <= cfg_data;
          ljpf_pkg::REG_FOUR_EPSILON: fe <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  initial errors = 0;

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// LJ pair force accumulator testbench
// Drives directed and random atom pairs through the accumulator under several
// register settings, with random idling on both sides and one long result
// stall; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 20000;  // cycles with no item moving
  localparam int DRAIN_WAIT  = 700;    // queue of four slow pairs plus margin

  logic                clk, rst;
  logic                push, full, empty, pop;
  ljpf_pkg::in_item_t  in_item;
  ljpf_pkg::out_item_t out_item;
  logic                cfg_valid, cfg_ready;
  logic [7:0]          cfg_index;
  logic [31:0]         cfg_data;
  int                  errors, pending;
  int                  sent;
  int                  quiet_cycles;
  logic                hold_off;   // long receiver stall
  logic                calm;       // stretch with no idling on either side

  lj_pair_force_accumulator dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lj_pair_force_checker chk (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // result side: random pops, held off by the stall process
  always @(posedge clk) begin
    if (rst || hold_off) pop <= 1'b0;
    else pop <= calm || ($urandom_range(99) >= 13);
  end

  // long stall once the random part is under way; the sender keeps pushing
  initial begin
    hold_off = 1'b0;
    wait (sent >= 200);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog on cycles in which nothing is accepted
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** lj_pair_force_accumulator: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one pair; returns on the edge where it is taken
  task automatic send_pair(input ljpf_pkg::in_item_t it);
    while (!calm && $urandom_range(99) < 13) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(negedge clk);
    while (full) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    sent++;
  endtask

  task automatic make_pair(input logic [31:0] hx, hy, hz, nx, ny, nz,
                           input logic lp, eop);
    ljpf_pkg::in_item_t it;
    it = '{hx, hy, hz, nx, ny, nz, lp, eop};
    send_pair(it);
  endtask

  // drain all results, then let slow pairs with no result finish
  task automatic settle();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_phase(input int ph);
    case (ph)
      1: begin  // short range, sigma of one angstrom
        write_reg(ljpf_pkg::REG_CUTOFF_SQ, 32'd16 << 16);
        write_reg(ljpf_pkg::REG_SIGMA6, 32'd1 << 16);
        write_reg(ljpf_pkg::REG_ENERGY_SHIFT, 32'd0);
        write_reg(ljpf_pkg::REG_FOUR_EPSILON, 32'd4 << 16);
        write_reg(8'd9, 32'hDEAD_BEEF);  // no such register, dropped
      end
      2: begin  // everything at the top, drives the sums into saturation
        write_reg(ljpf_pkg::REG_CUTOFF_SQ, 32'hFFFF_FFFF);
        write_reg(ljpf_pkg::REG_SIGMA6, 32'hFFFF_FFFF);
        write_reg(ljpf_pkg::REG_ENERGY_SHIFT, 32'h7FFF_FFFF);
        write_reg(ljpf_pkg::REG_FOUR_EPSILON, 32'hFFFF_FFFF);
      end
      3: begin  // everything at the bottom
        write_reg(ljpf_pkg::REG_CUTOFF_SQ, 32'd0);
        write_reg(ljpf_pkg::REG_SIGMA6, 32'd0);
        write_reg(ljpf_pkg::REG_ENERGY_SHIFT, 32'h8000_0000);
        write_reg(ljpf_pkg::REG_FOUR_EPSILON, 32'd0);
      end
      default: begin  // back to the power-up values
        write_reg(ljpf_pkg::REG_CUTOFF_SQ, ljpf_pkg::RST_CUTOFF_SQ);
        write_reg(ljpf_pkg::REG_SIGMA6, ljpf_pkg::RST_SIGMA6);
        write_reg(ljpf_pkg::REG_ENERGY_SHIFT, ljpf_pkg::RST_ENERGY_SHIFT);
        write_reg(ljpf_pkg::REG_FOUR_EPSILON, ljpf_pkg::RST_FOUR_EPSILON);
      end
    endcase
  endtask

  function automatic logic [31:0] jitter(logic [31:0] base, int unsigned span);
    return base + 32'($urandom_range(2 * span) - span);
  endfunction

  // mostly neighbor-list style pairs close to the home atom, some far ones,
  // some pure noise; runs close at random, a pass ends now and then
  task automatic random_pairs(input int n);
    ljpf_pkg::in_item_t it;
    int unsigned        kind, span;
    for (int i = 0; i < n; i++) begin
      calm <= (sent >= 320 && sent < 400);
      kind = $urandom_range(99);
      it.home_x = $urandom;
      it.home_y = $urandom;
      it.home_z = $urandom;
      if (kind < 85) begin
        span = (kind < 10) ? 255 : (kind < 70) ? (6 << 16) : (1 << 21);
        it.neighbor_x = jitter(it.home_x, span);
        it.neighbor_y = jitter(it.home_y, span);
        it.neighbor_z = jitter(it.home_z, span);
      end else begin
        it.neighbor_x = $urandom;
        it.neighbor_y = $urandom;
        it.neighbor_z = $urandom;
      end
      it.last_pair = ($urandom_range(4) == 0);
      it.end_of_pass = ($urandom_range(29) == 0);
      send_pair(it);
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    sent = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pairs under the power-up registers
    make_pair(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0);  // zero distance
    make_pair(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
              32'h0004_0000, 32'h0002_0000, 32'h0003_0000, 1'b0, 1'b0);  // 3 A, inside
    make_pair(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
              32'h0001_0000, 32'h0005_8000, 32'h0003_0000, 1'b1, 1'b0);  // 3.5 A
    make_pair(32'd0, 32'd0, 32'd0, 32'h0006_0000, 32'd0, 32'd0, 1'b1, 1'b0);  // past cutoff
    make_pair(32'd0, 32'd0, 32'd0, 32'hFFFA_0000, 32'd0, 32'd0, 1'b0, 1'b0);  // past, negative
    make_pair(32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 1'b0, 1'b0);  // very close
    make_pair(32'd5, 32'd7, 32'd9, 32'd4, 32'd8, 32'd9, 1'b1, 1'b0);  // very close
    make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);  // extreme span
    make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
    make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0002, 1'b0, 1'b0);
    make_pair(32'd0, 32'd0, 32'd0, 32'h0002_4000, 32'hFFFE_0000, 32'h0001_0000,
              1'b0, 1'b1);  // end of pass without last pair
    make_pair(32'h0010_0000, 32'd0, 32'd0, 32'h000C_0000, 32'd0, 32'd0, 1'b1, 1'b1);
    make_pair(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1);  // empty pass

    random_pairs(110);
    for (int ph = 1; ph <= 4; ph++) begin
      settle();
      program_phase(ph);
      random_pairs(ph == 4 ? 110 : 80);
    end
    settle();

    if (errors == 0) begin
      $display("** lj_pair_force_accumulator: PASSED **");
    end else begin
      $display("** lj_pair_force_accumulator: FAILED **");
    end
    $finish;
  end

endmodule
